@@ rtl/slx_pkg.sv @@
`default_nettype none

package slx_pkg;

  localparam int CoordW = 32;
  localparam int RegW   = 31;
  localparam int QBits  = 35;
  localparam int NumW   = 99;
  localparam int DenW   = 66;
  localparam int PosW   = 37;

  typedef enum logic {
    RegTol   = 1'b0,
    RegSlack = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] a_start_x;
    logic signed [CoordW-1:0] a_start_y;
    logic signed [CoordW-1:0] a_end_x;
    logic signed [CoordW-1:0] a_end_y;
    logic signed [CoordW-1:0] b_start_x;
    logic signed [CoordW-1:0] b_start_y;
    logic signed [CoordW-1:0] b_end_x;
    logic signed [CoordW-1:0] b_end_y;
  } in_t;

  typedef struct packed {
    logic                     found;
    logic signed [CoordW-1:0] cross_x;
  } out_t;

  typedef struct packed {
    logic                     va;
    logic                     vb;
    logic                     dz;
    logic                     ovf;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] x3;
    logic signed [CoordW-1:0] loa;
    logic signed [CoordW-1:0] hia;
    logic signed [CoordW-1:0] lob;
    logic signed [CoordW-1:0] hib;
  } side_t;

  typedef struct packed {
    logic [DenW-1:0]  rem;
    logic [QBits-1:0] low;
    logic [QBits-1:0] q;
    logic [DenW-1:0]  ad;
    logic             neg;
    side_t            side;
  } cell_t;

endpackage

`default_nettype wire

@@ rtl/segment_line_crossing_x.sv @@
// Crossing x of the lines through two segments, signed Q16.16 throughout.
// An item is taken on start_i whenever busy_o is low; busy_o stays low, so a
// new item can enter on every clock cycle and throughput is one item a cycle.
// Each item gives exactly one result, shown on result_o for one cycle with
// done_o high. The depth of the pipeline, and so the delay, is set by six
// front stages (differences, products and sign handling), a row of 35 divider
// cells that each settle one quotient bit, and three stages for the range test
// and the clamp. A quotient that cannot land in either span is flagged in the
// front and reported as not found. The receiver cannot hold results off.
// The configuration port writes the vertical tolerance (index 0) or the range
// slack (index 1) on any cycle with cfg_we_i high; write only while no item is
// in flight. Reset empties the pipeline, drops any item in flight, and sets
// the tolerance to 1 and the slack to 0.
`default_nettype none

module segment_line_crossing_x import slx_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire in_t             in_item_i,
  output logic                 done_o,
  output out_t                 result_o,
  input  wire logic            cfg_we_i,
  input  wire logic [0:0]      cfg_idx_i,
  input  wire logic [RegW-1:0] cfg_data_i
);

  localparam int NCell = QBits;

  logic [RegW-1:0] tol_q, slack_q;
  logic [NCell:0]  cv;
  cell_t           cd [NCell+1];

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= RegW'(1);
      slack_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegTol:   tol_q   <= cfg_data_i;
        RegSlack: slack_q <= cfg_data_i;
        default:  tol_q   <= tol_q;
      endcase
    end
  end

  slx_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .item_i  (in_item_i),
    .tol_i   (tol_q),
    .valid_o (cv[0]),
    .cell_o  (cd[0])
  );

  for (genvar k = 0; k < NCell; k++) begin : g_cell
    slx_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[k]),
      .cell_i  (cd[k]),
      .valid_o (cv[k+1]),
      .cell_o  (cd[k+1])
    );
  end

  slx_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (cv[NCell]),
    .cell_i   (cd[NCell]),
    .slack_i  (slack_q),
    .done_o   (done_o),
    .result_o (result_o)
  );

  a_zero_when_missing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.found |-> result_o.cross_x == '0)
    else $error("not-found result carries a nonzero x");

  a_row_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv[0] |-> ##(NCell) cv[NCell])
    else $error("item lost in divider row");

  a_tail_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv[NCell] |-> ##3 done_o)
    else $error("item lost after divider row");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cv[NCell], 3))
    else $error("result without an item");

endmodule

`default_nettype wire

@@ rtl/slx_front.sv @@
`default_nettype none

module slx_front import slx_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire in_t             item_i,
  input  wire logic [RegW-1:0] tol_i,
  output logic                 valid_o,
  output cell_t                cell_o
);

  logic [5:0] v_q;

  // Stage 1: differences, coordinate products, spans.
  logic signed [CoordW:0]     dxa1_q, dxb1_q, dya1_q, dyb1_q;
  logic signed [2*CoordW-1:0] p1_q, p2_q, p3_q, p4_q;
  side_t                      s1_q;

  // Stage 2.
  logic signed [2*CoordW:0]   ca2_q, cb2_q;
  logic signed [2*CoordW+1:0] m1_q, m2_q;
  logic signed [CoordW:0]     dxa2_q, dxb2_q;
  side_t                      s2_q;
  logic [CoordW:0]            absa, absb;

  // Stage 3.
  logic signed [2*CoordW+2:0] d3_q;
  logic signed [2*CoordW+1:0] pal_q, pah_q, pbl_q, pbh_q;
  side_t                      s3_q;

  // Stage 4.
  logic signed [NumW-1:0]     n4_q;
  logic signed [2*CoordW+2:0] d4_q;
  side_t                      s4_q;
  logic signed [NumW-1:0]     na, nb;

  // Stage 5.
  logic [NumW-1:0]            an5_q;
  logic [DenW-1:0]            ad5_q;
  logic                       neg5_q;
  side_t                      s5_q;
  logic signed [2*CoordW+2:0] dabs;

  side_t                      s2_d, s4_d, s6_d;

  assign absa = dxa1_q[CoordW] ? 33'(-dxa1_q) : 33'(dxa1_q);
  assign absb = dxb1_q[CoordW] ? 33'(-dxb1_q) : 33'(dxb1_q);
  assign na   = (99'(pah_q) <<< 32) + 99'(pal_q);
  assign nb   = (99'(pbh_q) <<< 32) + 99'(pbl_q);
  assign dabs = d4_q[2*CoordW+2] ? -d4_q : d4_q;

  always_comb begin
    s2_d     = s1_q;
    s2_d.va  = absa < {2'b00, tol_i};
    s2_d.vb  = absb < {2'b00, tol_i};
    s4_d     = s3_q;
    s4_d.dz  = d3_q == '0;
    s6_d     = s5_q;
    s6_d.ovf = DenW'(an5_q[NumW-1:QBits]) >= ad5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dxa1_q <= 33'(item_i.a_start_x) - 33'(item_i.a_end_x);
    dxb1_q <= 33'(item_i.b_start_x) - 33'(item_i.b_end_x);
    dya1_q <= 33'(item_i.a_start_y) - 33'(item_i.a_end_y);
    dyb1_q <= 33'(item_i.b_start_y) - 33'(item_i.b_end_y);
    p1_q   <= item_i.a_start_x * item_i.a_end_y;
    p2_q   <= item_i.a_start_y * item_i.a_end_x;
    p3_q   <= item_i.b_start_x * item_i.b_end_y;
    p4_q   <= item_i.b_start_y * item_i.b_end_x;
    s1_q.va  <= 1'b0;
    s1_q.vb  <= 1'b0;
    s1_q.dz  <= 1'b0;
    s1_q.ovf <= 1'b0;
    s1_q.x1  <= item_i.a_start_x;
    s1_q.x3  <= item_i.b_start_x;
    if (item_i.a_start_x < item_i.a_end_x) begin
      s1_q.loa <= item_i.a_start_x;
      s1_q.hia <= item_i.a_end_x;
    end else begin
      s1_q.loa <= item_i.a_end_x;
      s1_q.hia <= item_i.a_start_x;
    end
    if (item_i.b_start_x < item_i.b_end_x) begin
      s1_q.lob <= item_i.b_start_x;
      s1_q.hib <= item_i.b_end_x;
    end else begin
      s1_q.lob <= item_i.b_end_x;
      s1_q.hib <= item_i.b_start_x;
    end

    ca2_q   <= 65'(p1_q) - 65'(p2_q);
    cb2_q   <= 65'(p3_q) - 65'(p4_q);
    m1_q    <= dxa1_q * dyb1_q;
    m2_q    <= dya1_q * dxb1_q;
    dxa2_q  <= dxa1_q;
    dxb2_q  <= dxb1_q;
    s2_q    <= s2_d;

    d3_q  <= 67'(m1_q) - 67'(m2_q);
    pal_q <= $signed({1'b0, ca2_q[31:0]}) * dxb2_q;
    pah_q <= $signed(ca2_q[64:32]) * dxb2_q;
    pbl_q <= $signed({1'b0, cb2_q[31:0]}) * dxa2_q;
    pbh_q <= $signed(cb2_q[64:32]) * dxa2_q;
    s3_q  <= s2_q;

    n4_q    <= na - nb;
    d4_q    <= d3_q;
    s4_q    <= s4_d;

    an5_q  <= n4_q[NumW-1] ? 99'(-n4_q) : 99'(n4_q);
    ad5_q  <= dabs[DenW-1:0];
    neg5_q <= n4_q[NumW-1] ^ d4_q[2*CoordW+2];
    s5_q   <= s4_q;

    cell_o.rem      <= DenW'(an5_q[NumW-1:QBits]);
    cell_o.low      <= an5_q[QBits-1:0];
    cell_o.q        <= '0;
    cell_o.ad       <= ad5_q;
    cell_o.neg      <= neg5_q;
    cell_o.side     <= s6_d;
  end

  assign valid_o = v_q[5];

endmodule

`default_nettype wire

@@ rtl/slx_cell.sv @@
`default_nettype none

module slx_cell import slx_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire cell_t cell_i,
  output logic       valid_o,
  output cell_t      cell_o
);

  logic [DenW:0] trial;
  logic          ge;

  assign trial = {cell_i.rem, cell_i.low[QBits-1]};
  assign ge    = trial >= {1'b0, cell_i.ad};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_o.rem  <= ge ? DenW'(trial - {1'b0, cell_i.ad}) : DenW'(trial);
    cell_o.low  <= {cell_i.low[QBits-2:0], 1'b0};
    cell_o.q    <= {cell_i.q[QBits-2:0], ge};
    cell_o.ad   <= cell_i.ad;
    cell_o.neg  <= cell_i.neg;
    cell_o.side <= cell_i.side;
  end

endmodule

`default_nettype wire

@@ rtl/slx_back.sv @@
`default_nettype none

module slx_back import slx_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire cell_t           cell_i,
  input  wire logic [RegW-1:0] slack_i,
  output logic                 done_o,
  output out_t                 result_o
);

  logic [1:0] v_q;

  logic signed [PosW-1:0] qpos, qs, pos1_q, pos2_q, slk, lwa, hwa, lwb, hwb, c;
  logic                   fail1_q, fail2_q;
  side_t                  s1_q, s2_q;

  assign qpos = $signed({2'b00, cell_i.q});
  assign qs   = cell_i.neg ? (-qpos - $signed(37'(cell_i.rem != '0))) : qpos;
  assign slk  = $signed({6'b0, slack_i});
  assign lwa  = 37'(s1_q.loa) - slk;
  assign hwa  = 37'(s1_q.hia) + slk;
  assign lwb  = 37'(s1_q.lob) - slk;
  assign hwb  = 37'(s1_q.hib) + slk;

  always_comb begin
    c = pos2_q;
    if (c > 37'(s2_q.hia)) c = 37'(s2_q.hia);
    if (c > 37'(s2_q.hib)) c = 37'(s2_q.hib);
    if (c < 37'(s2_q.loa)) c = 37'(s2_q.loa);
    if (c < 37'(s2_q.lob)) c = 37'(s2_q.lob);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      done_o <= 1'b0;
    end else begin
      v_q    <= {v_q[0], valid_i};
      done_o <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= cell_i.side;
    if (cell_i.side.va) begin
      pos1_q <= 37'(cell_i.side.x1);
    end else if (cell_i.side.vb) begin
      pos1_q <= 37'(cell_i.side.x3);
    end else begin
      pos1_q <= qs;
    end
    fail1_q <= !cell_i.side.va && !cell_i.side.vb && (cell_i.side.dz || cell_i.side.ovf);

    s2_q    <= s1_q;
    pos2_q  <= pos1_q;
    fail2_q <= fail1_q || (pos1_q < lwa) || (pos1_q > hwa) || (pos1_q < lwb) ||
               (pos1_q > hwb);

    result_o.found   <= !fail2_q;
    result_o.cross_x <= fail2_q ? '0 : c[CoordW-1:0];
  end

endmodule

`default_nettype wire
